// ----- sv/ops_pkg.sv -----
// ============================================================================
// ops_pkg: shared types and constants of the obstacle potential stamp
// Beat payloads, configuration layout, opcodes and sequencer states.
// ============================================================================
package ops_pkg;

    // Default map geometry and stamp reach
    localparam int DEF_MAP_WIDTH  = 256;
    localparam int DEF_MAP_HEIGHT = 256;
    localparam int DEF_MAX_RING   = 15;

    // Depth of the command queue between front and back
    localparam int FQ_DEPTH = 2;

    // Configuration port layout
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SQ    = 1'd1;

    localparam logic [3:0]  RING_LIMIT_RST = 4'd5;
    localparam logic [15:0] PEAK_SQ_RST    = 16'd6400;

    // Opcodes
    localparam logic [1:0] OP_WRITE_OCC = 2'd0;
    localparam logic [1:0] OP_STAMP     = 2'd1;
    localparam logic [1:0] OP_READ_POT  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       occupied;
    } t_in_item;

    typedef struct packed {
        logic [15:0] potential;
        logic        cell_occupied;
    } t_out_item;

    // Classified command: the beat plus its in-map flag
    typedef struct packed {
        t_in_item item;
        logic     in_map;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_front_bus;

    typedef struct packed {
        logic [3:0]  ring_limit;
        logic [15:0] peak_sq;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STAMP,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

endpackage

// ----- sv/ops_ram.sv -----
// ============================================================================
// ops_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module ops_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ops_front.sv -----
// ============================================================================
// ops_front: input side of the obstacle potential stamp
// Accepts beats, flags cells that fall inside the map and queues them.
// ============================================================================
module ops_front #(
    parameter int MAP_WIDTH  = ops_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = ops_pkg::DEF_MAP_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_hold,
    input  logic                i_push,
    input  ops_pkg::t_in_item   i_item,
    output logic                o_full,
    output ops_pkg::t_front_bus o_bus,
    input  logic                i_take
);

    localparam int PW    = (ops_pkg::FQ_DEPTH > 1) ? $clog2(ops_pkg::FQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(ops_pkg::FQ_DEPTH + 1);
    localparam logic [PW-1:0]    PTR_LAST = PW'(ops_pkg::FQ_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ops_pkg::FQ_DEPTH);

    ops_pkg::t_cmd    r_q [ops_pkg::FQ_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic          acc;
    logic          pop_q;
    ops_pkg::t_cmd cmd_in;

    // classify: is the addressed cell on the map
    always_comb begin
        cmd_in.item   = i_item;
        cmd_in.in_map = (int'(i_item.cell_x) < MAP_WIDTH) &&
                        (int'(i_item.cell_y) < MAP_HEIGHT);
    end

    assign o_full = (r_count == CNT_FULL) || i_hold;
    assign acc    = i_push && !o_full;
    assign pop_q  = i_take && (r_count != '0);

    assign o_bus.valid = (r_count != '0);
    assign o_bus.cmd   = r_q[r_rd_ptr];

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (acc) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_q) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (acc && !pop_q) begin
            n_count = r_count + 1'b1;
        end else if (pop_q && !acc) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ----- sv/ops_back.sv -----
// ============================================================================
// ops_back: execution side of the obstacle potential stamp
// Owns both map memories, runs the clearing pass, the ring walk with its
// read-modify-write pipeline, cell lookups and the result register.
// ============================================================================
module ops_back #(
    parameter int MAP_WIDTH  = ops_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = ops_pkg::DEF_MAP_HEIGHT,
    parameter int MAX_RING   = ops_pkg::DEF_MAX_RING
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ops_pkg::t_cfg       i_cfg,
    input  ops_pkg::t_front_bus i_front,
    output logic                o_take,
    output logic                o_clearing,
    output logic                o_res_valid,
    output ops_pkg::t_out_item  o_res,
    input  logic                i_pop
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RING + 1);
    localparam int SW    = 2 * RW;
    localparam int DW    = SW + 1;
    localparam int DQW   = DW + 8;
    localparam int CMPW  = (DQW > 16) ? DQW : 16;
    localparam int MAXWH = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int XR    = (RW > 8) ? RW : 8;
    localparam int CW_A  = XR + 2;
    localparam int CW_B  = $clog2(MAXWH + 1) + 1;
    localparam int CW    = (CW_A > CW_B) ? CW_A : CW_B;

    localparam logic signed [CW-1:0] W_S      = CW'(MAP_WIDTH);
    localparam logic signed [CW-1:0] H_S      = CW'(MAP_HEIGHT);
    localparam logic [RW-1:0]        LIM_MAX  = RW'(MAX_RING);
    localparam logic [AW-1:0]        CLR_LAST = AW'(DEPTH - 1);

    // registers
    ops_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_clr_cnt, n_clr_cnt;
    ops_pkg::t_cmd      r_cmd, n_cmd;
    logic [RW-1:0]      r_lim, n_lim;
    logic signed [RW:0] r_dx, n_dx;
    logic signed [RW:0] r_dy, n_dy;
    logic               r_s1_valid, n_s1_valid;
    logic [AW-1:0]      r_s1_addr, n_s1_addr;
    logic [15:0]        r_s1_cand, n_s1_cand;
    logic               r_res_valid, n_res_valid;
    ops_pkg::t_out_item r_res, n_res;

    // control
    logic               take;
    logic               walk_start;
    logic               walk_step;
    logic               res_load;
    ops_pkg::t_out_item res_val;
    logic               slot_free;

    // memory ports
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               rd_occ;
    logic [15:0]        rd_pot;
    logic               occ_we;
    logic [AW-1:0]      occ_waddr;
    logic               occ_wdata;
    logic               pot_we;
    logic [AW-1:0]      pot_waddr;
    logic [15:0]        pot_wdata;
    logic               s1_write;

    // walk datapath
    logic [RW-1:0]      lim_sat;
    logic signed [RW:0] lim_sat_s;
    logic signed [RW:0] lim_s;
    logic               walk_last;
    logic signed [CW-1:0] nx, ny;
    logic [RW-1:0]      adx, ady;
    logic [SW-1:0]      sqx, sqy;
    logic [DW-1:0]      d2;
    logic [CMPW-1:0]    d2q;
    logic               nb_inside;
    logic               nb_in_reach;
    logic               nb_not_center;
    logic [AW-1:0]      nb_addr;
    logic [15:0]        nb_cand;
    logic [AW-1:0]      head_addr;
    logic [AW-1:0]      ctr_addr;

    // linear cell address, y-major
    function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
        return AW'(int'(y) * MAP_WIDTH + int'(x));
    endfunction

    assign head_addr = cell_addr(i_front.cmd.item.cell_x, i_front.cmd.item.cell_y);
    assign ctr_addr  = cell_addr(r_cmd.item.cell_x, r_cmd.item.cell_y);
    assign slot_free = !r_res_valid || i_pop;

    // ring count saturates at the build-time reach
    assign lim_sat   = (int'(i_cfg.ring_limit) > MAX_RING) ? LIM_MAX : RW'(i_cfg.ring_limit);
    assign lim_sat_s = $signed({1'b0, lim_sat});
    assign lim_s     = $signed({1'b0, r_lim});
    assign walk_last = (r_dx == lim_s) && (r_dy == lim_s);

    // neighbor coordinates and squared distance
    always_comb begin
        nx  = CW'($signed({1'b0, r_cmd.item.cell_x})) + CW'(r_dx);
        ny  = CW'($signed({1'b0, r_cmd.item.cell_y})) + CW'(r_dy);
        adx = r_dx[RW] ? RW'(-r_dx) : RW'(r_dx);
        ady = r_dy[RW] ? RW'(-r_dy) : RW'(r_dy);
        sqx = SW'(adx) * SW'(adx);
        sqy = SW'(ady) * SW'(ady);
        d2  = DW'(sqx) + DW'(sqy);
        d2q = CMPW'({d2, 8'h00});
        nb_inside     = (nx >= 0) && (nx < W_S) && (ny >= 0) && (ny < H_S);
        nb_in_reach   = d2q <= CMPW'(i_cfg.peak_sq);
        nb_not_center = (r_dx != 0) || (r_dy != 0);
        nb_addr       = AW'(int'(ny) * MAP_WIDTH + int'(nx));
        nb_cand       = i_cfg.peak_sq - d2q[15:0];
    end

    // second walk stage: raise the potential of a free cell
    assign s1_write = r_s1_valid && !rd_occ && (r_s1_cand > rd_pot);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ops_pkg::ST_CLEAR: begin
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = ops_pkg::ST_IDLE;
                end
            end
            ops_pkg::ST_IDLE: begin
                if (i_front.valid) begin
                    if (i_front.cmd.item.op == ops_pkg::OP_STAMP) begin
                        n_state = ops_pkg::ST_STAMP;
                    end else if (i_front.cmd.item.op != ops_pkg::OP_WRITE_OCC) begin
                        n_state = ops_pkg::ST_LOOKUP;
                    end
                end
            end
            ops_pkg::ST_STAMP: begin
                if (walk_last) begin
                    n_state = ops_pkg::ST_LOOKUP;
                end
            end
            ops_pkg::ST_LOOKUP: begin
                n_state = ops_pkg::ST_RESULT;
            end
            ops_pkg::ST_RESULT: begin
                if (slot_free) begin
                    n_state = ops_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ops_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        take       = 1'b0;
        walk_start = 1'b0;
        walk_step  = 1'b0;
        res_load   = 1'b0;
        res_val    = '0;
        rd_en      = 1'b0;
        rd_addr    = ctr_addr;
        occ_we     = 1'b0;
        occ_waddr  = head_addr;
        occ_wdata  = i_front.cmd.item.occupied;
        pot_we     = s1_write;
        pot_waddr  = r_s1_addr;
        pot_wdata  = r_s1_cand;
        o_clearing = 1'b0;
        unique case (r_state)
            ops_pkg::ST_CLEAR: begin
                o_clearing = 1'b1;
                occ_we     = 1'b1;
                occ_waddr  = r_clr_cnt;
                occ_wdata  = 1'b0;
                pot_we     = 1'b1;
                pot_waddr  = r_clr_cnt;
                pot_wdata  = '0;
            end
            ops_pkg::ST_IDLE: begin
                if (i_front.valid) begin
                    if (i_front.cmd.item.op == ops_pkg::OP_WRITE_OCC) begin
                        // occupancy write finishes here
                        if (slot_free) begin
                            take     = 1'b1;
                            occ_we   = i_front.cmd.in_map;
                            res_load = 1'b1;
                            res_val.cell_occupied = i_front.cmd.in_map &&
                                                    i_front.cmd.item.occupied;
                        end
                    end else begin
                        take       = 1'b1;
                        walk_start = (i_front.cmd.item.op == ops_pkg::OP_STAMP);
                    end
                end
            end
            ops_pkg::ST_STAMP: begin
                rd_en     = 1'b1;
                rd_addr   = nb_addr;
                walk_step = 1'b1;
            end
            ops_pkg::ST_LOOKUP: begin
                rd_en = 1'b1;
            end
            ops_pkg::ST_RESULT: begin
                if (slot_free) begin
                    res_load = 1'b1;
                    res_val.potential = (r_cmd.in_map &&
                                         r_cmd.item.op == ops_pkg::OP_READ_POT) ? rd_pot : '0;
                    res_val.cell_occupied = r_cmd.in_map && rd_occ;
                end
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_cmd       = r_cmd;
        n_lim       = r_lim;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_s1_valid  = walk_step && nb_inside && nb_in_reach && nb_not_center;
        n_s1_addr   = nb_addr;
        n_s1_cand   = nb_cand;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        if (r_state == ops_pkg::ST_CLEAR) begin
            n_clr_cnt = r_clr_cnt + 1'b1;
        end
        if (take) begin
            n_cmd = i_front.cmd;
        end
        if (walk_start) begin
            n_lim = lim_sat;
            n_dx  = -lim_sat_s;
            n_dy  = -lim_sat_s;
        end else if (walk_step) begin
            if (r_dx == lim_s) begin
                n_dx = -lim_s;
                n_dy = r_dy + 1'b1;
            end else begin
                n_dx = r_dx + 1'b1;
            end
        end
        if (res_load) begin
            n_res_valid = 1'b1;
            n_res       = res_val;
        end else if (i_pop) begin
            n_res_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ops_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_s1_valid  <= n_s1_valid;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_lim     <= n_lim;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_s1_addr <= n_s1_addr;
        r_s1_cand <= n_s1_cand;
        r_res     <= n_res;
    end

    assign o_take      = take;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // occupancy bitmap
    ops_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_occ)
    );

    // potential map
    ops_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_pot_ram (
        .i_clk   (i_clk),
        .i_we    (pot_we),
        .i_waddr (pot_waddr),
        .i_wdata (pot_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_pot)
    );

endmodule

// ----- sv/obstacle_potential_stamp.sv -----
// ============================================================================
// obstacle_potential_stamp: occupancy bitmap and obstacle potential map
// Top level: queue-style ports, configuration registers, front and back.
// ============================================================================
// After reset the block sweeps both maps clear, one cell a cycle, over all
// MAP_WIDTH*MAP_HEIGHT cells (65536 by default); full stays high until the
// sweep is done, while configuration writes are taken as usual. Beats enter
// a two-deep command queue, so a new beat is taken while a result waits to
// be popped. Once at the head of the queue, an occupancy write completes
// in the idle state, a potential read or unused op passes the lookup and
// result states, and a stamp walks (2L+1)^2 cells with L = min(ring_limit,
// MAX_RING) before those two states: the walk visits one neighbor per cycle
// through the single read port of the map memories, with the write-back of
// each cell overlapped with the read of the next.
module obstacle_potential_stamp #(
    parameter int MAP_WIDTH  = ops_pkg::DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = ops_pkg::DEF_MAP_HEIGHT,
    parameter int MAX_RING   = ops_pkg::DEF_MAX_RING
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    input  ops_pkg::t_in_item                i_in_item,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output ops_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [ops_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ops_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    ops_pkg::t_cfg       r_cfg, n_cfg;
    ops_pkg::t_front_bus front_bus;
    logic                take;
    logic                clearing;
    logic                res_valid;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ops_pkg::CFG_RING_LIMIT: n_cfg.ring_limit = i_cfg_wdata[3:0];
                ops_pkg::CFG_PEAK_SQ:    n_cfg.peak_sq    = i_cfg_wdata[15:0];
                default:                 n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_limit <= ops_pkg::RING_LIMIT_RST;
            r_cfg.peak_sq    <= ops_pkg::PEAK_SQ_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // command intake
    ops_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .o_bus   (front_bus),
        .i_take  (take)
    );

    // map engine and result register
    ops_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAX_RING   (MAX_RING)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_front     (front_bus),
        .o_take      (take),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_res       (o_out_item),
        .i_pop       (pop)
    );

    assign empty = !res_valid;

endmodule

// ----- test/tb_obstacle_potential_stamp.sv -----
// ============================================================================
// tb_obstacle_potential_stamp: self-checking bench for the potential stamp
// Drives occupancy writes, stamps and potential reads through the queue
// ports. A scoreboard keeps its own occupancy and potential maps and checks
// every result beat in order. Phases cover several register settings,
// including the extremes, and different sender idle and receiver stall rates.
// ============================================================================
module tb_obstacle_potential_stamp;

    localparam int MAP_W = ops_pkg::DEF_MAP_WIDTH;
    localparam int MAP_H = ops_pkg::DEF_MAP_HEIGHT;
    localparam int RING_MAX = ops_pkg::DEF_MAX_RING;
    localparam int IDX_W = ops_pkg::CFG_IDX_W;
    localparam int DATA_W = ops_pkg::CFG_DATA_W;

    // Op value with no defined action
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    // Clear sweep plus every beat a full-reach stamp, taken several times over
    localparam longint RUN_LIMIT = 64'd40_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of both maps and the registers
    // ------------------------------------------------------------------------
    class stamp_scoreboard;
        bit                 occ_map [MAP_W*MAP_H];
        bit   [15:0]        pot_map [MAP_W*MAP_H];
        bit   [3:0]         ring_limit;
        bit   [15:0]        peak_sq;
        ops_pkg::t_out_item expected_q [$];
        int                 n_fail;
        int                 n_checked;
        int                 n_op [4];

        function new();
            ring_limit = ops_pkg::RING_LIMIT_RST;
            peak_sq    = ops_pkg::PEAK_SQ_RST;
            n_fail     = 0;
            n_checked  = 0;
            foreach (n_op[i]) n_op[i] = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == ops_pkg::CFG_RING_LIMIT) ring_limit = data[3:0];
            else                                peak_sq    = data[15:0];
        endfunction

        function bit cell_in_map(int x, int y);
            return x >= 0 && x < MAP_W && y >= 0 && y < MAP_H;
        endfunction

        // Raise free neighbors within the cutoff to peak minus scaled d2
        function void stamp_around(int cx, int cy);
            int lim;
            int x;
            int y;
            int a;
            int d2q;
            int cand;
            lim = ring_limit;
            if (lim > RING_MAX) lim = RING_MAX;
            for (int dy = -lim; dy <= lim; dy++) begin
                for (int dx = -lim; dx <= lim; dx++) begin
                    x = cx + dx;
                    y = cy + dy;
                    if (dx == 0 && dy == 0) continue;
                    if (!cell_in_map(x, y)) continue;
                    d2q = (dx*dx + dy*dy) * 256;
                    if (d2q > int'(peak_sq)) continue;
                    a = y*MAP_W + x;
                    if (occ_map[a]) continue;
                    cand = int'(peak_sq) - d2q;
                    if (cand > int'(pot_map[a])) pot_map[a] = cand[15:0];
                end
            end
        endfunction

        // Accepted input beat: update the maps and queue the expected result
        function void note_beat(ops_pkg::t_in_item it);
            int x;
            int y;
            int a;
            ops_pkg::t_out_item r;
            x = it.cell_x;
            y = it.cell_y;
            a = y*MAP_W + x;
            r = '0;
            n_op[it.op]++;
            if (it.op == ops_pkg::OP_WRITE_OCC) begin
                if (cell_in_map(x, y)) occ_map[a] = it.occupied;
            end else if (it.op == ops_pkg::OP_STAMP) begin
                stamp_around(x, y);
            end
            if (cell_in_map(x, y)) begin
                r.cell_occupied = occ_map[a];
                if (it.op == ops_pkg::OP_READ_POT) r.potential = pot_map[a];
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Accepted result beat: compare with the oldest expectation
        function void check_beat(ops_pkg::t_out_item got);
            ops_pkg::t_out_item exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat potential=%0d cell_occupied=%0d",
                         $time, got.potential, got.cell_occupied);
                n_fail++;
                return;
            end
            exp_r = expected_q.pop_front();
            n_checked++;
            if (got.potential !== exp_r.potential) begin
                $display("%0t: potential expected %0d actual %0d",
                         $time, exp_r.potential, got.potential);
                n_fail++;
            end
            if (got.cell_occupied !== exp_r.cell_occupied) begin
                $display("%0t: cell_occupied expected %0d actual %0d",
                         $time, exp_r.cell_occupied, got.cell_occupied);
                n_fail++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    ops_pkg::t_in_item  i_in_item   = '0;
    logic               full;
    logic               empty;
    logic               pop         = 1'b0;
    ops_pkg::t_out_item o_out_item;
    logic               i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx   = '0;
    logic [DATA_W-1:0]  i_cfg_wdata = '0;

    int send_pct  = 0;
    int stall_pct = 0;

    stamp_scoreboard sb;

    obstacle_potential_stamp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (i_in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("obstacle_potential_stamp: mismatch");
        $finish;
    end

    // Beat monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_beat(i_in_item);
            if (pop && !empty) sb.check_beat(o_out_item);
        end
    end

    // Receiver: random stalls at the current rate
    initial begin
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks, always entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_beat(ops_pkg::t_in_item it);
        bit taken;
        while ($urandom_range(99) < send_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending until every expected result has been popped
    task automatic drain_results(int extra);
        push <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    function automatic ops_pkg::t_in_item mk_beat(logic [1:0] op, logic [7:0] x,
                                                  logic [7:0] y, logic occ);
        ops_pkg::t_in_item it;
        it.op       = op;
        it.cell_x   = x;
        it.cell_y   = y;
        it.occupied = occ;
        return it;
    endfunction

    // Hot spots sit on map edges often, so stamps get clipped
    function automatic logic [7:0] pick_hot();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random beat, mostly near a hot spot so stamps overlap and reads hit them
    function automatic ops_pkg::t_in_item gen_beat(logic [7:0] hx, logic [7:0] hy,
                                                   int reach);
        ops_pkg::t_in_item it;
        int r;
        r = $urandom_range(99);
        if (r < 30)      it.op = ops_pkg::OP_WRITE_OCC;
        else if (r < 52) it.op = ops_pkg::OP_STAMP;
        else if (r < 94) it.op = ops_pkg::OP_READ_POT;
        else             it.op = OP_UNUSED;
        if ($urandom_range(99) < 20) begin
            it.cell_x = 8'($urandom_range(255));
            it.cell_y = 8'($urandom_range(255));
        end else begin
            it.cell_x = hx + 8'($urandom_range(2*reach)) - 8'(reach);
            it.cell_y = hy + 8'($urandom_range(2*reach)) - 8'(reach);
        end
        it.occupied = ($urandom_range(99) < 40);
        return it;
    endfunction

    // Corner and edge stamps, occupied neighbors, cutoff, centre, unused op
    task automatic run_directed();
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd0,   8'd0,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_WRITE_OCC, 8'd1,   8'd1,   1'b1));
        send_beat(mk_beat(ops_pkg::OP_STAMP,     8'd0,   8'd0,   1'b1));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd1,   8'd0,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd1,   8'd1,   1'b1));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd0,   8'd0,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd5,   8'd0,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd4,   8'd3,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_WRITE_OCC, 8'd0,   8'd0,   1'b1));
        send_beat(mk_beat(OP_UNUSED,             8'd0,   8'd0,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_STAMP,     8'd255, 8'd255, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd254, 8'd254, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd250, 8'd255, 1'b1));
        send_beat(mk_beat(ops_pkg::OP_WRITE_OCC, 8'd254, 8'd255, 1'b1));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd254, 8'd255, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_STAMP,     8'd128, 8'd128, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_STAMP,     8'd128, 8'd128, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_WRITE_OCC, 8'd130, 8'd128, 1'b1));
        send_beat(mk_beat(ops_pkg::OP_STAMP,     8'd130, 8'd128, 1'b1));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd129, 8'd128, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd130, 8'd128, 1'b0));
        send_beat(mk_beat(ops_pkg::OP_WRITE_OCC, 8'd1,   8'd1,   1'b0));
        send_beat(mk_beat(ops_pkg::OP_READ_POT,  8'd1,   8'd1,   1'b0));
        send_beat(mk_beat(OP_UNUSED,             8'd255, 8'd255, 1'b1));
    endtask

    // One setting: optional register writes, random beats, then drain
    task automatic run_phase(bit write_cfg, logic [3:0] ring, logic [15:0] peak,
                             int s_pct, int r_pct, int count);
        logic [7:0] hx;
        logic [7:0] hy;
        if (write_cfg) begin
            // upper data bits are don't-care for the ring limit
            write_reg(ops_pkg::CFG_RING_LIMIT, {12'($urandom_range(4095)), ring});
            write_reg(ops_pkg::CFG_PEAK_SQ, peak);
        end
        send_pct  = s_pct;
        stall_pct = r_pct;
        hx = pick_hot();
        hy = pick_hot();
        for (int k = 0; k < count; k++) begin
            if (k % 16 == 0) begin
                hx = pick_hot();
                hy = pick_hot();
            end
            if (k == count/2) drain_results(0);
            send_beat(gen_beat(hx, hy, int'(sb.ring_limit) + 2));
        end
        drain_results(SETTLE_CYCLES);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values first
        run_directed();
        run_phase(1'b0, 4'd0,  16'd0,     0,  0,  60);
        run_phase(1'b1, 4'd15, 16'hFFFF,  52, 0,  40);
        run_phase(1'b1, 4'd0,  16'($urandom_range(65535)), 0, 52, 70);
        run_phase(1'b1, 4'd3,  16'd0,     18, 18, 70);
        run_phase(1'b1, 4'd7,  16'($urandom_range(65535)), 0, 0, 80);
        run_phase(1'b1, 4'd2,  16'($urandom_range(65535)), 52, 0, 80);
        run_phase(1'b1, 4'd1,  16'hFFFF,  0,  52, 80);
        run_phase(1'b1, 4'($urandom_range(6)), 16'($urandom_range(65535)), 18, 18, 80);
        run_phase(1'b1, 4'd15, 16'd2000,  0,  0,  20);

        $display("covered %0d occupancy writes, %0d stamps, %0d reads, %0d unused-op beats",
                 sb.n_op[ops_pkg::OP_WRITE_OCC], sb.n_op[ops_pkg::OP_STAMP],
                 sb.n_op[ops_pkg::OP_READ_POT], sb.n_op[OP_UNUSED]);
        $display("%0d results checked over ring limits 0..15 and peaks 0..65535, %0d errors",
                 sb.n_checked, sb.n_fail);
        if (sb.n_fail == 0)
            $display("obstacle_potential_stamp: match");
        else
            $display("obstacle_potential_stamp: mismatch");
        $finish;
    end

endmodule
